@@ sv/motion_record_playback_top_assert.svh @@
// Assertion macros for the motion record/playback block.
// The macros expect signals named clk and rst_n in the using module.
`ifndef MOTION_RECORD_PLAYBACK_TOP_ASSERT_SVH
`define MOTION_RECORD_PLAYBACK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MRP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define MRP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRP_ASSERT(label, cond, msg)
`define MRP_ASSERT_IMP(label, ante, cons, msg)
`define MRP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/mrp_pkg.sv @@
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int MAX_AXES    = 4;
    localparam int FRAMES      = 1024;
    localparam int DELTA_WIDTH = 16;
    localparam int POS_WIDTH   = 32;

    localparam int FIELD_W  = 32;                        // port width of pos/desired
    localparam int FRAME_W  = MAX_AXES * DELTA_WIDTH;
    localparam int FRAME_AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W    = $clog2(FRAMES + 1);
    localparam int AXIS_W   = 3;
    localparam int CAP_W    = 11;
    localparam int USER_W   = 6;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_PLAY   = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'd0,
        MODE_TREC    = 3'd1,
        MODE_REC     = 3'd2,
        MODE_TPLAY   = 3'd3,
        MODE_PLAY    = 3'd4
    } mode_t;

    typedef enum logic {
        REG_AXIS_COUNT = 1'b0,
        REG_CAPACITY   = 1'b1
    } reg_index_t;

    // per-beat command to the axis lanes
    typedef struct packed {
        logic latch;    // integrator takes the measured position
        logic accum;    // integrator adds the stored delta
        logic valid;    // targets are produced
        logic store;    // frame is written
    } lane_ctl_t;

    // flags of the result beat, listed from the high tuser bit down to bit 0
    typedef struct packed {
        logic pos_update;
        logic recording;
        logic playing;
        logic active;
        logic servo_on;
        logic desired_valid;
    } status_t;

endpackage

@@ sv/mrp_ram.sv @@
`timescale 1ns / 1ps

module mrp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/mrp_lane.sv @@
`timescale 1ns / 1ps

module mrp_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mrp_pkg::lane_ctl_t             ctl,
    input  logic                           lane_on,
    input  logic [mrp_pkg::FIELD_W-1:0]    pos,
    input  logic [mrp_pkg::DELTA_WIDTH-1:0] rdelta,
    output logic [mrp_pkg::DELTA_WIDTH-1:0] wdelta,
    output logic [mrp_pkg::FIELD_W-1:0]    desired
);

    import mrp_pkg::*;

    logic [POS_WIDTH-1:0] integ_reg;
    logic [POS_WIDTH-1:0] integ_next;
    logic [POS_WIDTH-1:0] pos_w;
    logic [POS_WIDTH-1:0] sum;
    logic [POS_WIDTH-1:0] diff;

    assign pos_w = pos[POS_WIDTH-1:0];
    assign sum   = integ_reg + POS_WIDTH'(signed'(rdelta));
    assign diff  = pos_w - integ_reg;

    // inactive lanes leave zero in the frame
    assign wdelta = lane_on ? diff[DELTA_WIDTH-1:0] : '0;

    always_comb
    begin
        integ_next = integ_reg;
        if (lane_on && ctl.latch)
        begin
            integ_next = pos_w;
        end
        else if (lane_on && ctl.accum)
        begin
            integ_next = sum;
        end
    end

    always_comb
    begin
        if (!(ctl.valid && lane_on))
        begin
            desired = '0;
        end
        else if (ctl.accum)
        begin
            desired = FIELD_W'(signed'(sum));
        end
        else
        begin
            desired = FIELD_W'(signed'(pos_w));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else
        begin
            integ_reg <= integ_next;
        end
    end

endmodule

@@ sv/mrp_ctrl.sv @@
`timescale 1ns / 1ps

module mrp_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  mrp_pkg::action_t             action,
    input  logic [mrp_pkg::CNT_W-1:0]    cap,
    output mrp_pkg::lane_ctl_t           ctl,
    output logic [mrp_pkg::FRAME_AW-1:0] wr_addr,
    output logic [mrp_pkg::FRAME_AW-1:0] rd_addr,
    output mrp_pkg::status_t             status
);

    import mrp_pkg::*;

    `include "motion_record_playback_top_assert.svh"

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [CNT_W-1:0] write_frame_reg;
    logic [CNT_W-1:0] write_frame_next;
    logic [CNT_W-1:0] read_frame_reg;
    logic [CNT_W-1:0] read_frame_next;
    logic             servo_reg;
    logic             servo_next;
    logic             rec_full;
    logic             play_end;

    // cap never exceeds FRAMES, so it also bounds the memory
    assign rec_full = (write_frame_reg >= cap);
    assign play_end = (read_frame_reg >= cap) || (read_frame_reg >= write_frame_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        write_frame_next = write_frame_reg;
        read_frame_next  = read_frame_reg;
        servo_next       = servo_reg;
        if (accept)
        begin
            case (action)
                ACT_RECORD:
                begin
                    write_frame_next = '0;
                    mode_next        = MODE_TREC;
                end
                ACT_PLAY:
                begin
                    read_frame_next = '0;
                    mode_next       = MODE_TPLAY;
                end
                ACT_STOP:
                begin
                    servo_next = 1'b0;
                    mode_next  = MODE_STANDBY;
                end
                default:
                begin
                    case (mode_reg)
                        MODE_TPLAY:
                        begin
                            servo_next = 1'b1;
                            mode_next  = MODE_PLAY;
                        end
                        MODE_PLAY:
                        begin
                            if (play_end)
                            begin
                                servo_next = 1'b0;
                                mode_next  = MODE_STANDBY;
                            end
                            else
                            begin
                                read_frame_next = read_frame_reg + CNT_W'(1);
                            end
                        end
                        MODE_TREC:
                        begin
                            servo_next = 1'b0;
                            mode_next  = MODE_REC;
                        end
                        MODE_REC:
                        begin
                            if (rec_full)
                            begin
                                mode_next = MODE_STANDBY;
                            end
                            else
                            begin
                                write_frame_next = write_frame_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        ctl = '0;
        if (accept && action == ACT_TICK)
        begin
            case (mode_reg)
                MODE_TPLAY:
                begin
                    ctl.latch = 1'b1;
                    ctl.valid = 1'b1;
                end
                MODE_PLAY:
                begin
                    ctl.accum = !play_end;
                    ctl.valid = !play_end;
                end
                MODE_TREC:
                begin
                    ctl.latch = 1'b1;
                end
                MODE_REC:
                begin
                    ctl.latch = !rec_full;
                    ctl.store = !rec_full;
                end
                default:
                begin
                end
            endcase
        end
        status.desired_valid = ctl.valid;
        status.servo_on      = servo_next;
        status.active        = (mode_next != MODE_STANDBY);
        status.playing       = (mode_next == MODE_TPLAY) || (mode_next == MODE_PLAY);
        status.recording     = (mode_next == MODE_TREC) || (mode_next == MODE_REC);
        status.pos_update    = (mode_next != MODE_PLAY);
    end

    // read ahead: the frame for the next beat is fetched as this one lands
    assign wr_addr = write_frame_reg[FRAME_AW-1:0];
    assign rd_addr = read_frame_next[FRAME_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STANDBY;
            write_frame_reg <= '0;
            read_frame_reg  <= '0;
            servo_reg       <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            write_frame_reg <= write_frame_next;
            read_frame_reg  <= read_frame_next;
            servo_reg       <= servo_next;
        end
    end

    `MRP_ASSERT(a_wr_bound, write_frame_reg <= CNT_W'(FRAMES), "write frame beyond memory")
    `MRP_ASSERT(a_rd_bound, read_frame_reg <= CNT_W'(FRAMES), "read frame beyond memory")
    `MRP_ASSERT_IMP(a_store_in_rec, ctl.store, mode_reg == MODE_REC && !rec_full,
                    "store outside record")

endmodule

@@ sv/motion_record_playback_top.sv @@
`timescale 1ns / 1ps

// channel   dir   handshake                  payload
// s_*       in    s_tvalid / s_tready        tuser: action; tdata: pos_0..pos_3
// m_*       out   m_tvalid / m_tready        tuser: flags;  tdata: desired_0..desired_3
// apb       in    psel / penable / pready    axis_count @0x0, capacity_frames @0x4
//
// One beat per cycle unless m_tready stalls; each yields one registered result.
// Rate is set by the per-axis lane adders and the one-frame-wide frame memory,
// which is read one beat ahead of use so playback never waits on it.
// rst_n is asynchronous; the frame memory is not cleared, playback only reads
// frames written by the last recording.
// s_tready drops only while a result waits in the output register.
module motion_record_playback_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_0, pos_1, pos_2, pos_3
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // desired_0, desired_1, desired_2, desired_3
    output logic [5:0]   m_tuser,   // desired_valid, servo_on, active, playing,
                                    // recording, position_update
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    import mrp_pkg::*;

    `include "motion_record_playback_top_assert.svh"

    logic [AXIS_W-1:0]  axis_count_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    logic [AXIS_W-1:0]  na;
    logic [CNT_W-1:0]   cap;

    logic               accept;
    lane_ctl_t          ctl;
    status_t            status;
    logic [FRAME_AW-1:0] wr_addr;
    logic [FRAME_AW-1:0] rd_addr;
    logic [FRAME_W-1:0] wframe;
    logic [FRAME_W-1:0] rframe;
    logic [FIELD_W-1:0] desired [MAX_AXES];

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [127:0]       out_data_reg;
    logic [127:0]       out_data_next;
    logic [USER_W-1:0]  out_user_reg;

    // configuration
    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_AXIS_COUNT: prdata = 32'(axis_count_reg);
            REG_CAPACITY:   prdata = 32'(capacity_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= AXIS_W'(MAX_AXES);
            capacity_reg   <= CAP_W'(FRAMES);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_AXIS_COUNT: axis_count_reg <= pwdata[AXIS_W-1:0];
                REG_CAPACITY:   capacity_reg   <= pwdata[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign na  = (axis_count_reg > AXIS_W'(MAX_AXES)) ? AXIS_W'(MAX_AXES) : axis_count_reg;
    assign cap = (32'(capacity_reg) > 32'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(capacity_reg);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mrp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (action_t'(s_tuser)),
        .cap     (cap),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .status  (status)
    );

    for (genvar a = 0; a < MAX_AXES; a++)
    begin : g_lane
        mrp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .lane_on (32'(na) > a),
            .pos     (s_tdata[a*FIELD_W +: FIELD_W]),
            .rdelta  (rframe[a*DELTA_WIDTH +: DELTA_WIDTH]),
            .wdelta  (wframe[a*DELTA_WIDTH +: DELTA_WIDTH]),
            .desired (desired[a])
        );
    end

    mrp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAMES)
    ) u_frames (
        .clk   (clk),
        .we    (ctl.store),
        .waddr (wr_addr),
        .wdata (wframe),
        .raddr (rd_addr),
        .rdata (rframe)
    );

    // merge lane targets into the result beat; axes beyond the axis count read zero
    always_comb
    begin
        out_data_next = '0;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            out_data_next[a*FIELD_W +: FIELD_W] = desired[a];
        end
    end

    assign out_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `MRP_ASSERT_NEXT(a_beat_out, accept, m_tvalid, "accepted beat gave no result")
    `MRP_ASSERT_IMP(a_valid_plays, m_tvalid && m_tuser[0], m_tuser[3] && !m_tuser[5],
                    "targets outside steady play")
    `MRP_ASSERT_IMP(a_idle_quiet, m_tvalid && !m_tuser[2], !m_tuser[0] && !m_tuser[3],
                    "standby result claims play")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mrp_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        action_t          act;
        logic [3:0][31:0] pos;
    } motion_beat_t;

    typedef struct packed {
        logic [3:0][31:0] desired;
        status_t          flags;
    } target_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;     // pos_0, pos_1, pos_2, pos_3
    logic [1:0]   s_tuser = '0;     // action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // desired_0, desired_1, desired_2, desired_3
    logic [5:0]   m_tuser;          // desired_valid, servo_on, active, playing,
                                    // recording, position_update
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    motion_record_playback_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted block state
    mode_t       cur_mode = MODE_STANDBY;
    int          rec_len = 0;
    int          play_idx = 0;
    logic [31:0] integ [MAX_AXES] = '{default: '0};
    logic        servo_en = 1'b0;
    logic [63:0] frame_mem [FRAMES];
    logic [2:0]  axis_cfg = 3'd4;
    logic [10:0] cap_cfg = 11'd1024;

    motion_beat_t beat_q [$];
    target_t      target_q [$];
    motion_beat_t cur_beat;
    logic [31:0]  gen_pos [4] = '{default: '0};
    int           pushed_n = 0;
    int           src_idle = 18;
    int           snk_idle = 69;
    int           err_cnt = 0;
    int           stall_cycles = 0;
    string        flag_name [6] = '{"desired_valid", "servo_on", "active", "playing",
                                    "recording", "position_update"};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic target_t predict_motion(motion_beat_t b);
        target_t     t;
        int          na;
        int          cap;
        logic [63:0] fr;
        logic [31:0] d;
        logic        valid;
        t = '0;
        valid = 1'b0;
        na = (axis_cfg > MAX_AXES) ? MAX_AXES : int'(axis_cfg);
        cap = (cap_cfg > FRAMES) ? FRAMES : int'(cap_cfg);
        case (b.act)
            ACT_RECORD:
            begin
                rec_len = 0;
                cur_mode = MODE_TREC;
            end
            ACT_PLAY:
            begin
                play_idx = 0;
                cur_mode = MODE_TPLAY;
            end
            ACT_STOP:
            begin
                servo_en = 1'b0;
                cur_mode = MODE_STANDBY;
            end
            default:
            begin
                case (cur_mode)
                    MODE_TPLAY:
                    begin
                        for (int a = 0; a < na; a++)
                        begin
                            integ[a] = b.pos[a];
                            t.desired[a] = integ[a];
                        end
                        valid = 1'b1;
                        servo_en = 1'b1;
                        cur_mode = MODE_PLAY;
                    end
                    MODE_PLAY:
                    begin
                        if (play_idx >= cap || play_idx >= rec_len)
                        begin
                            servo_en = 1'b0;
                            cur_mode = MODE_STANDBY;
                        end
                        else
                        begin
                            fr = frame_mem[play_idx];
                            for (int a = 0; a < na; a++)
                            begin
                                integ[a] = integ[a] + {{16{fr[16*a+15]}}, fr[16*a +: 16]};
                                t.desired[a] = integ[a];
                            end
                            play_idx++;
                            valid = 1'b1;
                        end
                    end
                    MODE_TREC:
                    begin
                        for (int a = 0; a < na; a++)
                            integ[a] = b.pos[a];
                        servo_en = 1'b0;
                        cur_mode = MODE_REC;
                    end
                    MODE_REC:
                    begin
                        if (rec_len >= cap)
                            cur_mode = MODE_STANDBY;
                        else
                        begin
                            // lanes of inactive axes stay zero
                            fr = '0;
                            for (int a = 0; a < na; a++)
                            begin
                                d = b.pos[a] - integ[a];
                                fr[16*a +: 16] = d[15:0];
                                integ[a] = b.pos[a];
                            end
                            frame_mem[rec_len] = fr;
                            rec_len++;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        t.flags.desired_valid = valid;
        t.flags.servo_on = servo_en;
        t.flags.active = (cur_mode != MODE_STANDBY);
        t.flags.playing = (cur_mode == MODE_TPLAY || cur_mode == MODE_PLAY);
        t.flags.recording = (cur_mode == MODE_TREC || cur_mode == MODE_REC);
        t.flags.pos_update = (cur_mode != MODE_PLAY);
        return t;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                target_q.push_back(predict_motion(cur_beat));
            if (!s_tvalid || s_tready)
            begin
                if (beat_q.size() != 0 && $urandom_range(99) >= src_idle)
                begin
                    cur_beat = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_beat.pos;
                    s_tuser <= cur_beat.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        target_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (target_q.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual %h %h",
                         $time, m_tdata, m_tuser);
                err_cnt++;
            end
            else
            begin
                want = target_q.pop_front();
                for (int a = 0; a < 4; a++)
                    if (m_tdata[32*a +: 32] !== want.desired[a])
                    begin
                        $display("%0t desired_%0d: expected %h, actual %h",
                                 $time, a, want.desired[a], m_tdata[32*a +: 32]);
                        err_cnt++;
                    end
                for (int f = 0; f < 6; f++)
                    if (m_tuser[f] !== want.flags[f])
                    begin
                        $display("%0t %s: expected %b, actual %b",
                                 $time, flag_name[f], want.flags[f], m_tuser[f]);
                        err_cnt++;
                    end
            end
        end
    end

    // counts cycles with no beat and no register access
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [3:0][31:0] pos4(logic [31:0] p0, logic [31:0] p1,
                                             logic [31:0] p2, logic [31:0] p3);
        return {p3, p2, p1, p0};
    endfunction

    function automatic void push_beat(action_t act, logic [3:0][31:0] pos);
        motion_beat_t b;
        b.act = act;
        b.pos = pos;
        beat_q.push_back(b);
        pushed_n++;
    endfunction

    function automatic logic [3:0][31:0] random_pos();
        return pos4($urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic [31:0] near_pos(logic [31:0] base);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return base + 32'($urandom_range(65535)) - 32'd32768;
        else if (r < 90)
            return $urandom;
        else if ($urandom_range(1))
            return 32'h7FFF_FFFF - 32'($urandom_range(255));
        else
            return 32'h8000_0000 + 32'($urandom_range(255));
    endfunction

    function automatic void push_tick();
        logic [3:0][31:0] p;
        for (int a = 0; a < 4; a++)
        begin
            gen_pos[a] = near_pos(gen_pos[a]);
            p[a] = gen_pos[a];
        end
        push_beat(ACT_TICK, p);
    endfunction

    // record and play runs with random content, plus some loose commands
    function automatic void queue_sessions(int n);
        int start;
        int r;
        start = pushed_n;
        while (pushed_n - start < n)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                push_beat(ACT_RECORD, random_pos());
                repeat ($urandom_range(1, 30)) push_tick();
                if ($urandom_range(1))
                    push_beat(ACT_STOP, random_pos());
            end
            else if (r < 85)
            begin
                push_beat(ACT_PLAY, random_pos());
                // seed close to the top so the sums wrap
                if ($urandom_range(2) == 0)
                    for (int a = 0; a < 4; a++)
                        gen_pos[a] = 32'h7FFF_F000 + 32'($urandom_range(8191));
                repeat ($urandom_range(1, 35)) push_tick();
                if ($urandom_range(2) == 0)
                    push_beat(ACT_STOP, random_pos());
            end
            else
                repeat ($urandom_range(1, 4))
                    push_beat(action_t'($urandom_range(3)), random_pos());
        end
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || s_tvalid || target_q.size() != 0);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_AXIS_COUNT)
            axis_cfg = val[2:0];
        else
            cap_cfg = val[10:0];
    endtask

    initial
    begin
        int axis_set [6];
        int cap_set [6];
        axis_set = '{1, 7, 0, 3, 4, 2};
        cap_set = '{5, 2047, 0, 1024, 17, 1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // standby ticks and commands at the extremes
        push_beat(ACT_TICK, pos4(32'h0, 32'h0, 32'h0, 32'h0));
        push_beat(ACT_TICK, pos4(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_beat(ACT_STOP, pos4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // recording with delta extremes and wrapping deltas
        push_beat(ACT_RECORD, random_pos());
        push_beat(ACT_TICK, pos4(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF));
        push_beat(ACT_TICK, pos4(32'h8000_0000, 32'h8000_7FFF, 32'hFFFF_8000, 32'h0000_FFFE));
        push_beat(ACT_TICK, pos4(32'h1234_5678, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0000));
        push_beat(ACT_TICK, pos4(32'h1234_5678, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0000));
        // playback seeded at the top so integrators wrap; ends at recorded length
        push_beat(ACT_PLAY, random_pos());
        push_beat(ACT_TICK, pos4(32'h7FFF_FFFF, 32'h7FFF_8000, 32'h8000_0000, 32'h0));
        repeat (5) push_beat(ACT_TICK, random_pos());
        // stop during record, stop during play, empty recording
        push_beat(ACT_RECORD, random_pos());
        push_beat(ACT_TICK, random_pos());
        push_beat(ACT_STOP, random_pos());
        push_beat(ACT_PLAY, random_pos());
        push_beat(ACT_TICK, random_pos());
        push_beat(ACT_STOP, random_pos());
        push_beat(ACT_TICK, random_pos());
        push_beat(ACT_PLAY, random_pos());
        push_beat(ACT_PLAY, random_pos());
        push_beat(ACT_TICK, random_pos());
        push_beat(ACT_TICK, random_pos());
        wait_idle();

        for (int s = 0; s < 6; s++)
        begin
            case (s / 2)
                0:
                begin
                    src_idle = 18;
                    snk_idle = 69;
                end
                1:
                begin
                    src_idle = 69;
                    snk_idle = 18;
                end
                default:
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            repeat (2) @(posedge clk);
            write_reg(REG_AXIS_COUNT, axis_set[s]);
            write_reg(REG_CAPACITY, cap_set[s]);
            // two halves; the sender holds off until all results are back
            for (int h = 0; h < 2; h++)
            begin
                queue_sessions(78);
                wait_idle();
            end
        end

        repeat (4) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
